FILE: sv/assert_macros.svh
// Assertion macros for the RTL of the rank filter.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SRF_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define SRF_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define SRF_ASSERT(label, prop)
`define SRF_NEVER(label, expr)
`endif
`endif

FILE: sv/srf_pkg.sv
// Shared types and codes for the sliding window rank filter.
// No dependencies.
`timescale 1ns / 1ps
package srf_pkg;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 5;
  localparam int COUNT_W = 5;
  localparam logic [COUNT_W-1:0] COUNT_SAT = 5'd31;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_SIZE = 1'b0,
    CFG_MODE        = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_MIN    = 2'd0,
    MODE_MAX    = 2'd1,
    MODE_AVG    = 2'd2,
    MODE_MEDIAN = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_LOAD,
    S_SCAN,
    S_DSTART,
    S_DWAIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic shift;
    logic load;
    logic scan;
  } cell_ctrl_t;

endpackage

FILE: sv/srf_if.sv
// Stream interfaces for the rank filter: sample input and filtered output.
// Uses no package.
`timescale 1ns / 1ps
interface srf_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last_in;
  modport source (output valid, sample, last_in, input ready);
  modport sink   (input valid, sample, last_in, output ready);
endinterface

interface srf_out_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] value;
  logic                          last_out;
  modport source (output valid, value, last_out, input ready);
  modport sink   (input valid, value, last_out, output ready);
endinterface

FILE: sv/srf_cell.sv
// One cell of the window chain: holds a line sample, a rotating copy for the
// rank scan, and its rank counters. Depends on srf_pkg.
`timescale 1ns / 1ps
module srf_cell #(
  parameter int SAMPLE_BITS = 16,
  parameter int WIN_W = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  srf_pkg::cell_ctrl_t           ctrl,
  input  logic                          active,
  input  logic signed [SAMPLE_BITS-1:0] line_in,
  input  logic signed [SAMPLE_BITS-1:0] rot_in,
  input  logic signed [SAMPLE_BITS-1:0] bcast,
  input  logic [WIN_W-1:0]              rank,
  output logic signed [SAMPLE_BITS-1:0] key,
  output logic signed [SAMPLE_BITS-1:0] rot,
  output logic signed [SAMPLE_BITS-1:0] sel
);

  logic signed [SAMPLE_BITS-1:0] key_r, rot_r;
  logic [WIN_W-1:0] less_r, eq_r;
  logic [WIN_W:0]   upper;
  logic             match;

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      key_r <= '0;
    end else if (ctrl.shift) begin
      key_r <= line_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rot_r  <= key_r;
      less_r <= '0;
      eq_r   <= '0;
    end else if (ctrl.scan) begin
      rot_r <= rot_in;
      if (active && (bcast < key_r)) less_r <= less_r + 1'b1;
      if (active && (bcast == key_r)) eq_r <= eq_r + 1'b1;
    end
  end

  // this cell's value sits at sorted places less .. less+eq-1
  assign upper = {1'b0, less_r} + {1'b0, eq_r};
  assign match = active && (less_r <= rank) && ({1'b0, rank} < upper);
  assign key   = key_r;
  assign rot   = rot_r;
  assign sel   = match ? key_r : '0;

endmodule

FILE: sv/srf_div.sv
// Restoring divider, one quotient bit per cycle, for the window average.
// Depends on nothing.
`timescale 1ns / 1ps
module srf_div #(
  parameter int SUM_W = 21,
  parameter int WIN_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [WIN_W-1:0] divisor,
  output logic             busy,
  output logic [SUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [WIN_W-1:0] rem_r;
  logic [SUM_W-1:0] quot_r;
  logic [WIN_W:0]   rem_sh, rem_sub;
  logic             ge;

  assign rem_sh  = {rem_r, quot_r[SUM_W-1]};
  assign ge      = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == CNT_W'(SUM_W - 1)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r  <= '0;
      rem_r  <= '0;
      quot_r <= dividend;
    end else if (busy_r) begin
      cnt_r  <= cnt_r + 1'b1;
      rem_r  <= ge ? rem_sub[WIN_W-1:0] : rem_sh[WIN_W-1:0];
      quot_r <= {quot_r[SUM_W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign quotient = quot_r;

endmodule

FILE: sv/sliding_window_rank_filter_unit.sv
// Sliding window rank filter: minimum, maximum, average or median over a
// centered odd window of w samples, zero padded at both array ends. A sample
// that yields no result is taken in idle; one that yields a result holds the
// input through load, rank scan and emit, with divider start and wait before
// emit for average. Each flushed position at array end adds a shift and the
// same steps. The scan streams the w window samples one per cycle past the
// cells; the average adds a bit-serial divider of SUM_W = SAMPLE_BITS +
// clog2(MAX_WINDOW+1) bits. Depends on srf_pkg, srf_if, srf_cell and srf_div.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sliding_window_rank_filter_unit #(
  parameter int MAX_WINDOW = 31,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  srf_in_if.sink                           in_ch,
  srf_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [srf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int WIN_W = $clog2(MAX_WINDOW + 1);
  localparam int CW = (WIN_W > srf_pkg::COUNT_W) ? WIN_W : srf_pkg::COUNT_W;
  localparam int TOP_WIN = (MAX_WINDOW % 2 == 1) ? MAX_WINDOW : MAX_WINDOW - 1;
  localparam int SUM_W = SAMPLE_BITS + WIN_W;

  srf_pkg::state_t state_r, state_nxt;
  logic [4:0] ws_r;
  srf_pkg::mode_t mode_r;
  logic [srf_pkg::COUNT_W-1:0] seen_r, seen_nxt;
  logic [WIN_W-1:0] pend_r, pend_nxt, cnt_r, cnt_nxt;
  logic flush_r, flush_nxt, last_r, last_nxt;
  logic signed [SUM_W-1:0] acc_r, acc_nxt;
  logic out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_value_r;
  logic out_last_r;

  logic [CW-1:0] w_c, seen_c, seen_inc_c, h_c;
  logic [WIN_W-1:0] w_eff, h, rank;
  srf_pkg::cell_ctrl_t ctrl;
  logic signed [SAMPLE_BITS-1:0] shift_val, bcast, sel_or, result;
  logic signed [SAMPLE_BITS-1:0] keys [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] rots [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] sels [MAX_WINDOW];
  logic in_fire, out_load, div_start, div_busy, acc_neg;
  logic [SUM_W-1:0] acc_abs, quot, mean_u;

  // effective window: forced odd, at least 3, at most the largest odd <= MAX
  always_comb begin
    w_c = CW'(ws_r) | CW'(1);
    if (w_c < CW'(3)) w_c = CW'(3);
    if (w_c > CW'(TOP_WIN)) w_c = CW'(TOP_WIN);
  end
  assign w_eff = w_c[WIN_W-1:0];
  assign h     = w_eff >> 1;
  assign h_c   = CW'(h);
  assign seen_c = CW'(seen_r);
  assign seen_inc_c = CW'(seen_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r   <= 5'd3;
      mode_r <= srf_pkg::MODE_MIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        srf_pkg::CFG_WINDOW_SIZE: ws_r <= cfg_wdata[4:0];
        srf_pkg::CFG_MODE:        mode_r <= srf_pkg::mode_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (mode_r)
      srf_pkg::MODE_MIN: rank = '0;
      srf_pkg::MODE_MAX: rank = w_eff - 1'b1;
      default:           rank = h;
    endcase
  end

  // cell chain: line shifts toward higher index, scan copy toward index 0
  assign bcast = rots[0];
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] lin, rin;
    if (i == 0) begin : g_head
      assign lin = shift_val;
    end else begin : g_body
      assign lin = keys[i-1];
    end
    if (i == MAX_WINDOW - 1) begin : g_tail
      assign rin = '0;
    end else begin : g_mid
      assign rin = rots[i+1];
    end
    srf_cell #(.SAMPLE_BITS(SAMPLE_BITS), .WIN_W(WIN_W)) u_cell (
      .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .active(WIN_W'(i) < w_eff),
      .line_in(lin), .rot_in(rin), .bcast(bcast), .rank(rank),
      .key(keys[i]), .rot(rots[i]), .sel(sels[i])
    );
  end

  // all matching cells hold the same value, so OR picks it
  always_comb begin
    sel_or = '0;
    for (int i = 0; i < MAX_WINDOW; i++) sel_or = sel_or | sels[i];
  end

  assign acc_neg = acc_r[SUM_W-1];
  assign acc_abs = acc_neg ? SUM_W'(-acc_r) : SUM_W'(acc_r);

  srf_div #(.SUM_W(SUM_W), .WIN_W(WIN_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(acc_abs),
    .divisor(w_eff), .busy(div_busy), .quotient(quot)
  );

  assign mean_u = acc_neg ? (~quot + 1'b1) : quot;
  assign result = (mode_r == srf_pkg::MODE_AVG) ? mean_u[SAMPLE_BITS-1:0] : sel_or;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == srf_pkg::S_EMIT) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = (state_r == srf_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    seen_nxt  = seen_r;
    pend_nxt  = pend_r;
    flush_nxt = flush_r;
    last_nxt  = last_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    ctrl      = '0;
    shift_val = '0;
    div_start = 1'b0;
    unique case (state_r)
      srf_pkg::S_IDLE: begin
        if (in_fire) begin
          ctrl.shift = 1'b1;
          shift_val  = in_ch.sample;
          seen_nxt   = (seen_r == srf_pkg::COUNT_SAT) ? seen_r : seen_r + 1'b1;
          pend_nxt   = (seen_inc_c < h_c) ? WIN_W'(seen_inc_c) : h;
          last_nxt   = in_ch.last_in;
          if (seen_c >= h_c) begin
            state_nxt = srf_pkg::S_LOAD;
          end else if (in_ch.last_in) begin
            flush_nxt = 1'b1;
            state_nxt = srf_pkg::S_SHIFT;
          end
        end
      end
      srf_pkg::S_SHIFT: begin
        ctrl.shift = 1'b1;
        pend_nxt   = pend_r - 1'b1;
        state_nxt  = srf_pkg::S_LOAD;
      end
      srf_pkg::S_LOAD: begin
        ctrl.load = 1'b1;
        acc_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = srf_pkg::S_SCAN;
      end
      srf_pkg::S_SCAN: begin
        ctrl.scan = 1'b1;
        acc_nxt   = acc_r + SUM_W'(bcast);
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == w_eff - 1'b1) begin
          state_nxt = (mode_r == srf_pkg::MODE_AVG) ? srf_pkg::S_DSTART : srf_pkg::S_EMIT;
        end
      end
      srf_pkg::S_DSTART: begin
        div_start = 1'b1;
        state_nxt = srf_pkg::S_DWAIT;
      end
      srf_pkg::S_DWAIT: begin
        if (!div_busy) state_nxt = srf_pkg::S_EMIT;
      end
      srf_pkg::S_EMIT: begin
        if (out_load) begin
          if (flush_r) begin
            if (pend_r == '0) begin
              ctrl.clear = 1'b1;
              seen_nxt   = '0;
              flush_nxt  = 1'b0;
              state_nxt  = srf_pkg::S_IDLE;
            end else begin
              state_nxt = srf_pkg::S_SHIFT;
            end
          end else if (last_r) begin
            flush_nxt = 1'b1;
            state_nxt = srf_pkg::S_SHIFT;
          end else begin
            state_nxt = srf_pkg::S_IDLE;
          end
        end
      end
      default: state_nxt = srf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srf_pkg::S_IDLE;
      seen_r  <= '0;
      pend_r  <= '0;
      flush_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      seen_r  <= seen_nxt;
      pend_r  <= pend_nxt;
      flush_r <= flush_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= result;
      out_last_r  <= flush_r && (pend_r == '0);
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.value    = out_value_r;
  assign out_ch.last_out = out_last_r;

  `SRF_NEVER(a_scan_range, state_r == srf_pkg::S_SCAN && cnt_r >= w_eff)
  `SRF_ASSERT(a_div_runs, state_r == srf_pkg::S_DSTART |=> div_busy)
  `SRF_NEVER(a_idle_div, state_r == srf_pkg::S_IDLE && div_busy)
  `SRF_ASSERT(a_array_clear, out_load && flush_r && pend_r == '0 |=> seen_r == '0)

endmodule

FILE: bench/tb.sv
// Self-checking bench for sliding_window_rank_filter_unit: a directed table of
// samples, then random arrays, checked against an in-bench window predictor.
// Depends on srf_pkg, srf_if and the rank filter RTL.
`timescale 1ns / 1ps
module tb;

  localparam int MAXW = 31;
  localparam int SB = 16;

  typedef struct {
    logic signed [SB-1:0] value;
    logic                 last_out;
  } result_t;

  typedef struct {
    logic signed [SB-1:0] sample;
    logic                 last_in;
    logic                 has_exp;   // typed expectation for the first result
    logic signed [SB-1:0] exp_value;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [srf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [srf_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  srf_in_if #(.SAMPLE_BITS(SB)) in_ch ();
  srf_out_if #(.SAMPLE_BITS(SB)) out_ch ();

  sliding_window_rank_filter_unit #(.MAX_WINDOW(MAXW), .SAMPLE_BITS(SB)) DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [4:0] win_size_reg;
  srf_pkg::mode_t mode_reg;
  logic signed [SB-1:0] line_q [MAXW];
  int unsigned seen_cnt;

  result_t expected_q[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic int eff_window();
    int w;
    w = int'(win_size_reg) | 1;
    if (w < 3) w = 3;
    if (w > MAXW) w = MAXW;
    return w;
  endfunction

  function automatic logic signed [SB-1:0] window_reduce(int w);
    logic signed [SB-1:0] sorted [MAXW];
    logic signed [SB-1:0] r, t;
    longint acc;
    r = line_q[0];
    acc = 0;
    case (mode_reg)
      srf_pkg::MODE_MIN: for (int i = 1; i < w; i++) if (line_q[i] < r) r = line_q[i];
      srf_pkg::MODE_MAX: for (int i = 1; i < w; i++) if (line_q[i] > r) r = line_q[i];
      srf_pkg::MODE_AVG: begin
        for (int i = 0; i < w; i++) acc += line_q[i];
        r = SB'(acc / w);  // SV division truncates toward zero
      end
      default: begin
        for (int i = 0; i < w; i++) sorted[i] = line_q[i];
        for (int i = 1; i < w; i++)
          for (int j = i; j > 0 && sorted[j-1] > sorted[j]; j--) begin
            t = sorted[j]; sorted[j] = sorted[j-1]; sorted[j-1] = t;
          end
        r = sorted[w >> 1];
      end
    endcase
    return r;
  endfunction

  function automatic void line_push(logic signed [SB-1:0] v);
    for (int i = MAXW - 1; i > 0; i--) line_q[i] = line_q[i-1];
    line_q[0] = v;
  endfunction

  // returns number of results queued for this sample
  function automatic int predict_sample(logic signed [SB-1:0] s, logic lst);
    int w, h, pend, n;
    result_t r;
    w = eff_window();
    h = w >> 1;
    n = 0;
    line_push(s);
    if (seen_cnt >= h) begin
      r.value = window_reduce(w); r.last_out = 1'b0;
      expected_q.push_back(r); n++;
    end
    if (seen_cnt < 31) seen_cnt++;
    if (lst) begin
      pend = (seen_cnt < h) ? seen_cnt : h;
      for (int i = 0; i < pend; i++) begin
        line_push('0);
        r.value = window_reduce(w); r.last_out = (i + 1 == pend);
        expected_q.push_back(r); n++;
      end
      for (int i = 0; i < MAXW; i++) line_q[i] = '0;
      seen_cnt = 0;
    end
    return n;
  endfunction

  task automatic cfg_write(srf_pkg::cfg_idx_t idx, logic [srf_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == srf_pkg::CFG_WINDOW_SIZE) win_size_reg = data;
    else mode_reg = srf_pkg::mode_t'(data[1:0]);
    @(posedge clk);
  endtask

  // valid stays up after the accepting edge until the next transaction or drain
  task automatic send_sample(logic signed [SB-1:0] s, logic lst);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1; in_ch.sample <= s; in_ch.last_in <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    void'(predict_sample(s, lst));
  endtask

  // block is idle once queue drains and the longest flush step has passed
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic send_array(int len, int kind);
    logic signed [SB-1:0] s;
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: s = SB'($urandom);
        1: s = SB'(int'($urandom_range(7)) - 4);
        default: s = ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
      endcase
      send_sample(s, i == len - 1);
    end
  endtask

  // receiver with random stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result value=%0d last=%0b", out_ch.value, out_ch.last_out);
        end else begin
          result_t e;
          e = expected_q.pop_front();
          if (e.value !== out_ch.value || e.last_out !== out_ch.last_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected value=%0d last=%0b, got value=%0d last=%0b",
                       e.value, e.last_out, out_ch.value, out_ch.last_out);
          end
        end
      end
      out_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  stim_row_t dir_tab[$];

  task automatic run_directed();
    stim_row_t row;
    int n;
    // size 3, min: two one-sample arrays, each one flushed result, then a 4-sample array
    dir_tab = '{
      '{16'sh7fff, 1'b1, 1'b1, 16'sh0000},
      '{16'sh8000, 1'b1, 1'b1, 16'sh8000},
      '{16'sh0005, 1'b0, 1'b0, 16'sh0},
      '{16'sh7fff, 1'b0, 1'b1, 16'sh0000},
      '{16'sh8000, 1'b0, 1'b1, 16'sh8000},
      '{-16'sh0003, 1'b1, 1'b1, 16'sh8000}
    };
    foreach (dir_tab[k]) begin
      row = dir_tab[k];
      n = expected_q.size();
      send_sample(row.sample, row.last_in);
      if (row.has_exp && expected_q.size() > n && expected_q[n].value !== row.exp_value) begin
        mismatches++;
        if (mismatches <= 10)
          $display("table row %0d: predictor %0d, table %0d", k, expected_q[n].value,
                   row.exp_value);
      end
    end
    drain();
    // every mode and extreme sizes, including even and below-minimum sizes
    for (int m = 0; m < 4; m++) begin
      cfg_write(srf_pkg::CFG_MODE, 5'(m));
      cfg_write(srf_pkg::CFG_WINDOW_SIZE,
                (m == 0) ? 5'd31 : (m == 1) ? 5'd4 : (m == 2) ? 5'd0 : 5'd1);
      send_array(4, 2);
      drain();
    end
  endtask

  initial begin
    in_ch.valid = 1'b0; in_ch.sample = '0; in_ch.last_in = 1'b0;
    win_size_reg = 5'd3; mode_reg = srf_pkg::MODE_MIN; seen_cnt = 0;
    for (int i = 0; i < MAXW; i++) line_q[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 8 : 65) : 0;
      recv_stall_pct = (ph == 2) ? 65 : (ph == 3) ? 8 : 0;
      for (int a = 0; a < 5; a++) begin
        cfg_write(srf_pkg::CFG_MODE, 5'($urandom_range(3)));
        cfg_write(srf_pkg::CFG_WINDOW_SIZE,
                  ($urandom_range(5) == 0) ? 5'd31 : 5'($urandom_range(2, 9)));
        send_array(int'($urandom_range(1, 18)), $urandom_range(4) == 0 ? 1 : 0);
        drain();
      end
    end
    send_idle_pct = 0; recv_stall_pct = 0;
    drain();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end
endmodule
